// File: hdl/sfd_pkg.sv
// Shared types, constants and codes of the serial frame deframer.
`default_nettype none

package sfd_pkg;

    // Window geometry
    localparam int WIN_DEPTH = 20;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    typedef logic [7:0]        byte_t;
    typedef logic [WIN_AW-1:0] win_addr_t;
    typedef logic [FILL_W-1:0] win_fill_t;

    // Frame lengths in bytes
    localparam win_fill_t LEN_SHORT    = FILL_W'(8);
    localparam win_fill_t LEN_POLL     = FILL_W'(18);
    localparam win_fill_t LEN_POLL_EXT = FILL_W'(20);
    localparam win_fill_t WIN_FULL     = FILL_W'(WIN_DEPTH);

    // Configuration register reset values
    localparam byte_t HEADER_RST  = 8'hEA;
    localparam byte_t TRAILER_RST = 8'h0A;
    localparam byte_t DEVICE_RST  = 8'h01;
    localparam byte_t POLL_RST    = 8'hAA;

    typedef enum logic [1:0] {
        CFG_HEADER  = 2'd0,
        CFG_TRAILER = 2'd1,
        CFG_DEVICE  = 2'd2,
        CFG_POLL    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_SHORT    = 2'd0,
        KIND_POLL     = 2'd1,
        KIND_POLL_EXT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_HEAD_W,
        ST_SCAN,
        ST_CMD,
        ST_CHECK,
        ST_EMIT
    } seq_state_t;

    // One result beat
    typedef struct packed {
        byte_t      content_byte;
        logic [3:0] content_index;
        kind_t      frame_kind;
        logic       last_of_frame;
    } beat_t;

    // Output queue status seen by the sequencer
    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } ofifo_stat_t;

endpackage

`default_nettype wire

// File: hdl/sfd_window_ram.sv
// Byte window memory: one write port, one registered read port.
`default_nettype none

module sfd_window_ram (
    input  wire                logic aclk,
    input  wire                logic wr_en,
    input  wire sfd_pkg::win_addr_t wr_addr,
    input  wire sfd_pkg::byte_t     wr_data,
    input  wire                logic rd_en,
    input  wire sfd_pkg::win_addr_t rd_addr,
    output sfd_pkg::byte_t          rd_data
);
    import sfd_pkg::*;

    byte_t mem [WIN_DEPTH];

    // Write and read in one clocked block, with registered read data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/sfd_out_fifo.sv
// Two-entry result queue between the sequencer and the output channel.
`default_nettype none

module sfd_out_fifo (
    input  wire                 logic aclk,
    input  wire                 logic aresetn,
    input  wire                 logic push,
    input  wire sfd_pkg::beat_t      push_beat,
    output logic                     m_valid,
    input  wire                 logic m_ready,
    output sfd_pkg::beat_t           m_beat,
    output sfd_pkg::ofifo_stat_t     stat
);
    import sfd_pkg::*;

    beat_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign m_valid    = (count_reg != 2'd0);
    assign m_beat     = slot_reg[rd_ptr_reg];
    assign pop        = m_valid && m_ready;
    assign stat.count = count_reg;
    assign stat.pop   = pop;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the beat payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != 2'd2) || pop)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

`default_nettype wire

// File: hdl/serial_frame_deframer_resync.sv
// Serial frame deframer: window sequencer, configuration and top-level ports.
//
// Usage: received bytes enter on the s_ channel (s_valid/s_ready, s_rx_byte).
// Each byte is appended to a 20-byte window held in a one-port-read memory.
// The sequencer then looks for a header byte, waits while a frame is partial,
// checks device code, checksum and trailer, and on success sends the command
// and data bytes as beats on the m_ channel with index, frame kind and a last
// marker. A failed frame loses its first byte and the window is rescanned,
// but a poll frame failed at 18 bytes is first retried at 20 or waits.
// Window bytes are visited one at a time through the single memory read
// port; content beats are issued one per cycle while emitting, unless the
// result queue is full. s_ready is high only while the sequencer is idle.
// Results pass through a two-entry queue, so a stalled receiver holds
// emission but the next byte is still taken once the frame has been queued
// out. Reset empties the window and loads the default header, trailer,
// device and poll codes; memory contents are not cleared. Configuration
// writes (cfg_wr_en, cfg_index, cfg_data) take effect at once.
`default_nettype none

module serial_frame_deframer_resync (
    input  wire  logic       aclk,
    input  wire  logic       aresetn,
    input  wire  logic       s_valid,
    output logic             s_ready,
    input  wire  logic [7:0] s_rx_byte,
    output logic             m_valid,
    input  wire  logic       m_ready,
    output logic [7:0]       m_content_byte,
    output logic [3:0]       m_content_index,
    output logic [1:0]       m_frame_kind,
    output logic             m_last_of_frame,
    input  wire  logic       cfg_wr_en,
    input  wire  logic [1:0] cfg_index,
    input  wire  logic [7:0] cfg_data
);
    import sfd_pkg::*;

    localparam logic [WIN_AW:0] DEPTH_X = (WIN_AW + 1)'(WIN_DEPTH);

    // Map a window offset onto a memory address
    function automatic win_addr_t win_addr(input win_addr_t base, input win_fill_t off);
        logic [WIN_AW:0] s;
        s = {1'b0, base} + {1'b0, WIN_AW'(off)};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[WIN_AW-1:0];
    endfunction

    // Configuration registers
    byte_t header_reg, trailer_reg, device_reg, poll_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= HEADER_RST;
            trailer_reg <= TRAILER_RST;
            device_reg  <= DEVICE_RST;
            poll_reg    <= POLL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HEADER:  header_reg  <= cfg_data;
                CFG_TRAILER: trailer_reg <= cfg_data;
                CFG_DEVICE:  device_reg  <= cfg_data;
                CFG_POLL:    poll_reg    <= cfg_data;
                default:     header_reg  <= header_reg;
            endcase
        end
    end

    // Sequencer state
    seq_state_t state_reg, state_next;
    win_addr_t  head_reg, head_next;
    win_fill_t  fill_reg, fill_next;
    win_fill_t  cur_reg, cur_next;
    win_fill_t  len_reg, len_next;
    kind_t      kind_reg, kind_next;
    byte_t      sum_reg, sum_next;
    logic       ok_reg, ok_next;
    win_fill_t  e_reg, e_next;
    logic       pend_reg, pend_next;
    win_fill_t  pend_idx_reg, pend_idx_next;

    // Memory and queue interface
    logic        wr_en, rd_en;
    win_addr_t   wr_addr, rd_addr;
    win_fill_t   rd_off;
    byte_t       rd_data;
    logic        push;
    beat_t       push_beat, m_beat;
    ofifo_stat_t ofs;

    win_fill_t   n_content;
    logic [2:0]  occ;
    logic        can_issue;
    logic        term_ok;

    assign n_content = len_reg - FILL_W'(4);
    assign occ       = {1'b0, ofs.count} + {2'b00, pend_reg};
    assign can_issue = (occ < 3'd2) || ((occ == 3'd2) && ofs.pop);
    assign rd_addr   = win_addr(head_reg, rd_off);
    assign wr_addr   = win_addr(head_reg, fill_reg);

    // Per-byte verdict while checking a frame
    always_comb begin
        term_ok = 1'b1;
        if (cur_reg == FILL_W'(1)) begin
            term_ok = (rd_data == device_reg);
        end else if (cur_reg == len_reg - FILL_W'(2)) begin
            term_ok = (rd_data == sum_reg);
        end else if (cur_reg == len_reg - FILL_W'(1)) begin
            term_ok = (rd_data == trailer_reg);
        end
    end

    // Queue a fetched content byte
    always_comb begin
        push                    = pend_reg;
        push_beat.content_byte  = rd_data;
        push_beat.content_index = pend_idx_reg[3:0];
        push_beat.frame_kind    = kind_reg;
        push_beat.last_of_frame = (pend_idx_reg == n_content - FILL_W'(1));
    end

    // Next state and memory accesses
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        cur_next      = cur_reg;
        len_next      = len_reg;
        kind_next     = kind_reg;
        sum_next      = sum_reg;
        ok_next       = ok_reg;
        e_next        = e_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        s_ready       = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_off        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    wr_en      = 1'b1;
                    fill_next  = fill_reg + FILL_W'(1);
                    state_next = ST_HEAD;
                end
            end

            ST_HEAD: begin
                if (fill_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_off     = '0;
                    state_next = ST_HEAD_W;
                end
            end

            ST_HEAD_W: begin
                if (rd_data != header_reg) begin
                    // rescan from the second byte
                    if (fill_reg > FILL_W'(1)) begin
                        rd_en      = 1'b1;
                        rd_off     = FILL_W'(1);
                        cur_next   = FILL_W'(1);
                        state_next = ST_SCAN;
                    end else begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end else if (fill_reg < LEN_SHORT) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_off     = FILL_W'(2);
                    state_next = ST_CMD;
                end
            end

            ST_SCAN: begin
                if (rd_data == header_reg) begin
                    // drop the bytes before the header
                    head_next  = win_addr(head_reg, cur_reg);
                    fill_next  = fill_reg - cur_reg;
                    state_next = ST_HEAD;
                end else if (cur_reg + FILL_W'(1) < fill_reg) begin
                    rd_en    = 1'b1;
                    rd_off   = cur_reg + FILL_W'(1);
                    cur_next = cur_reg + FILL_W'(1);
                end else begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_CMD: begin
                if (rd_data == poll_reg) begin
                    if (fill_reg >= LEN_POLL) begin
                        len_next   = LEN_POLL;
                        kind_next  = KIND_POLL;
                        rd_en      = 1'b1;
                        rd_off     = FILL_W'(1);
                        cur_next   = FILL_W'(1);
                        sum_next   = '0;
                        ok_next    = 1'b1;
                        state_next = ST_CHECK;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    len_next   = LEN_SHORT;
                    kind_next  = KIND_SHORT;
                    rd_en      = 1'b1;
                    rd_off     = FILL_W'(1);
                    cur_next   = FILL_W'(1);
                    sum_next   = '0;
                    ok_next    = 1'b1;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                if ((cur_reg >= FILL_W'(2)) && (cur_reg <= len_reg - FILL_W'(3))) begin
                    sum_next = sum_reg + rd_data;
                end
                if (cur_reg != len_reg - FILL_W'(1)) begin
                    rd_en    = 1'b1;
                    rd_off   = cur_reg + FILL_W'(1);
                    cur_next = cur_reg + FILL_W'(1);
                    ok_next  = ok_reg && term_ok;
                end else if (ok_reg && term_ok) begin
                    e_next     = '0;
                    state_next = ST_EMIT;
                end else if (kind_reg == KIND_POLL) begin
                    // short poll frame failed: try the long form or wait
                    if (fill_reg >= LEN_POLL_EXT) begin
                        len_next  = LEN_POLL_EXT;
                        kind_next = KIND_POLL_EXT;
                        rd_en     = 1'b1;
                        rd_off    = FILL_W'(1);
                        cur_next  = FILL_W'(1);
                        sum_next  = '0;
                        ok_next   = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    rd_en      = 1'b1;
                    rd_off     = FILL_W'(1);
                    cur_next   = FILL_W'(1);
                    state_next = ST_SCAN;
                end
            end

            ST_EMIT: begin
                if ((e_reg < n_content) && can_issue) begin
                    rd_en         = 1'b1;
                    rd_off        = e_reg + FILL_W'(2);
                    pend_next     = 1'b1;
                    pend_idx_next = e_reg;
                    e_next        = e_reg + FILL_W'(1);
                end else if ((e_reg == n_content) && !pend_reg) begin
                    // remove the frame from the window
                    head_next  = win_addr(head_reg, len_reg);
                    fill_next  = fill_reg - len_reg;
                    state_next = ST_HEAD;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        len_reg      <= len_next;
        kind_reg     <= kind_next;
        sum_reg      <= sum_next;
        ok_reg       <= ok_next;
        e_reg        <= e_next;
        pend_idx_reg <= pend_idx_next;
    end

    sfd_window_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfd_out_fifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .stat      (ofs)
    );

    assign m_content_byte  = m_beat.content_byte;
    assign m_content_index = m_beat.content_index;
    assign m_frame_kind    = m_beat.frame_kind;
    assign m_last_of_frame = m_beat.last_of_frame;

    a_idle_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (fill_reg < WIN_FULL))
        else $error("window full while idle");

    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("accepted beat not appended to window");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < WIN_AW'(WIN_DEPTH))
        else $error("window head out of range");

endmodule

`default_nettype wire

// File: verif/sfd_frame_checker.sv
// Scoreboard for the serial frame deframer: mirrors the byte window and checks each result beat.
`timescale 1ns / 100ps

module sfd_frame_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_content_byte,
    input  wire logic [3:0] m_content_index,
    input  wire logic [1:0] m_frame_kind,
    input  wire logic       m_last_of_frame,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output int              fail_count,
    output int              beats_due
);

    import sfd_pkg::*;

    localparam int MAX_BEATS_PER_BYTE = 16;

    // Mirror of the receive window and the frame codes
    byte_t win_bytes [WIN_DEPTH];
    int    win_fill = 0;
    byte_t header_cfg  = HEADER_RST;
    byte_t trailer_cfg = TRAILER_RST;
    byte_t device_cfg  = DEVICE_RST;
    byte_t poll_cfg    = POLL_RST;

    // Content beats still owed by the block, oldest first
    beat_t content_beats_due [$];
    int    fails_seen = 0;

    // Discard n bytes from the front of the window
    task automatic drop_front(input int n);
        if (n >= win_fill) begin
            win_fill = 0;
        end else begin
            for (int k = 0; k + n < win_fill; k++)
                win_bytes[k] = win_bytes[k + n];
            win_fill -= n;
        end
    endtask

    // Advance the window to the next header byte at or after start, or empty it
    task automatic seek_header(input int start);
        bit found;
        found = 1'b0;
        for (int k = start; k < win_fill && !found; k++) begin
            if (win_bytes[k] == header_cfg) begin
                drop_front(k);
                found = 1'b1;
            end
        end
        if (!found)
            win_fill = 0;
    endtask

    // Trailer, device code and checksum of a frame of len bytes at the window front
    function automatic bit frame_good(input int len);
        byte_t csum;
        csum = 8'h00;
        if (len < int'(LEN_SHORT) || len > win_fill)
            return 1'b0;
        if (win_bytes[len - 1] != trailer_cfg || win_bytes[1] != device_cfg)
            return 1'b0;
        for (int i = 2; i + 3 <= len; i++)
            csum += win_bytes[i];
        return csum == win_bytes[len - 2];
    endfunction

    // Take one received byte and queue the content beats of the frames it completes, up to MAX_BEATS_PER_BYTE beats
    task automatic deframe_byte(input byte_t rx);
        int    produced;
        int    flen;
        kind_t fkind;
        bit    hold;
        beat_t bt;
        produced = 0;
        hold     = 1'b0;
        if (win_fill >= WIN_DEPTH)
            drop_front(1);
        win_bytes[win_fill] = rx;
        win_fill++;

        while (!hold) begin
            flen  = 0;
            fkind = KIND_SHORT;
            if (win_fill == 0) begin
                hold = 1'b1;
            end else if (win_bytes[0] != header_cfg) begin
                seek_header(1);
            end else if (win_fill < int'(LEN_SHORT)) begin
                hold = 1'b1;
            end else begin
                if (win_bytes[2] == poll_cfg) begin
                    // poll frames close at 18 bytes if they can, else at 20
                    if (win_fill >= int'(LEN_POLL) && frame_good(int'(LEN_POLL))) begin
                        flen  = int'(LEN_POLL);
                        fkind = KIND_POLL;
                    end else if (win_fill >= int'(LEN_POLL_EXT)
                                 && frame_good(int'(LEN_POLL_EXT))) begin
                        flen  = int'(LEN_POLL_EXT);
                        fkind = KIND_POLL_EXT;
                    end else if (win_fill < int'(LEN_POLL_EXT) && win_fill < WIN_DEPTH) begin
                        hold = 1'b1;
                    end
                end else if (frame_good(int'(LEN_SHORT))) begin
                    flen  = int'(LEN_SHORT);
                    fkind = KIND_SHORT;
                end

                if (!hold) begin
                    if (flen == 0) begin
                        // bad frame: lose the header and resync
                        seek_header(1);
                    end else if (produced + flen - 4 > MAX_BEATS_PER_BYTE) begin
                        hold = 1'b1;
                    end else begin
                        for (int i = 0; i < flen - 4; i++) begin
                            bt.content_byte  = win_bytes[2 + i];
                            bt.content_index = 4'(i);
                            bt.frame_kind    = fkind;
                            bt.last_of_frame = (i + 1 == flen - 4);
                            content_beats_due = {content_beats_due, bt};
                        end
                        produced += flen - 4;
                        drop_front(flen);
                    end
                end
            end
        end
    endtask

    // Watch configuration, input and result beats on every edge
    always @(posedge aclk) begin : watch
        beat_t want;
        if (!aresetn) begin
            win_fill    = 0;
            header_cfg  = HEADER_RST;
            trailer_cfg = TRAILER_RST;
            device_cfg  = DEVICE_RST;
            poll_cfg    = POLL_RST;
            content_beats_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_HEADER:  header_cfg  = cfg_data;
                    CFG_TRAILER: trailer_cfg = cfg_data;
                    CFG_DEVICE:  device_cfg  = cfg_data;
                    CFG_POLL:    poll_cfg    = cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                deframe_byte(s_rx_byte);

            if (m_valid && m_ready) begin
                if (content_beats_due.size() == 0) begin
                    $error("unexpected result beat: content_byte %0h content_index %0d",
                           m_content_byte, m_content_index);
                    fails_seen++;
                end else begin
                    want = content_beats_due.pop_front();
                    if (m_content_byte !== want.content_byte) begin
                        $error("content_byte: expected %0h, got %0h",
                               want.content_byte, m_content_byte);
                        fails_seen++;
                    end
                    if (m_content_index !== want.content_index) begin
                        $error("content_index: expected %0d, got %0d",
                               want.content_index, m_content_index);
                        fails_seen++;
                    end
                    if (m_frame_kind !== want.frame_kind) begin
                        $error("frame_kind: expected %0d, got %0d",
                               want.frame_kind, m_frame_kind);
                        fails_seen++;
                    end
                    if (m_last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               want.last_of_frame, m_last_of_frame);
                        fails_seen++;
                    end
                end
            end
        end
        fail_count <= fails_seen;
        beats_due  <= content_beats_due.size();
    end

endmodule

// File: verif/tb.sv
// Testbench top for the serial frame deframer: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    import sfd_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 400;
    localparam int LIMIT_CYCLES   = 2000000;
    localparam int PHASE_BYTES    = 92;
    localparam int NUM_PHASES     = 5;

    typedef enum {FRAME_INTACT, FRAME_DAMAGED, FRAME_CUT} frame_mod_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_content_byte;
    logic [3:0] m_content_index;
    logic [1:0] m_frame_kind;
    logic       m_last_of_frame;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = CFG_HEADER;
    logic [7:0] cfg_data  = 8'h00;

    int fail_count;
    int beats_due;
    int cycle_count;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // Codes currently loaded, used to build frames
    byte_t hdr_val  = HEADER_RST;
    byte_t trl_val  = TRAILER_RST;
    byte_t dev_val  = DEVICE_RST;
    byte_t poll_val = POLL_RST;

    byte_t stim_bytes [$];

    always #(HALF_PERIOD_NS) aclk = ~aclk;

    serial_frame_deframer_resync i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_content_byte  (m_content_byte),
        .m_content_index (m_content_index),
        .m_frame_kind    (m_frame_kind),
        .m_last_of_frame (m_last_of_frame),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    sfd_frame_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_content_byte  (m_content_byte),
        .m_content_index (m_content_index),
        .m_frame_kind    (m_frame_kind),
        .m_last_of_frame (m_last_of_frame),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .beats_due       (beats_due)
    );

    // Stall the result channel at the rate of the current phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(input byte_t b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the sender until every owed beat has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beats_due != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input byte_t v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
    endtask

    task automatic load_registers(input byte_t h, input byte_t t, input byte_t d, input byte_t p);
        cfg_write(CFG_HEADER, h);
        cfg_write(CFG_TRAILER, t);
        cfg_write(CFG_DEVICE, d);
        cfg_write(CFG_POLL, p);
        cfg_wr_en <= 1'b0;
        hdr_val  = h;
        trl_val  = t;
        dev_val  = d;
        poll_val = p;
    endtask

    // Append a frame of the given kind, intact, with one byte damaged, or cut short
    task automatic append_frame(input kind_t kind, input frame_mod_t how);
        byte_t fr [WIN_DEPTH];
        byte_t csum;
        int    len;
        int    keep;
        int    pos;
        len = (kind == KIND_SHORT) ? int'(LEN_SHORT) :
              (kind == KIND_POLL)  ? int'(LEN_POLL)  : int'(LEN_POLL_EXT);
        fr[0] = hdr_val;
        fr[1] = dev_val;
        fr[2] = poll_val;
        if (kind == KIND_SHORT) begin
            while (fr[2] == poll_val)
                fr[2] = byte_t'($urandom);
        end
        for (int i = 3; i < len - 2; i++)
            fr[i] = byte_t'($urandom);
        // a 20-byte poll frame must not already close at 18 bytes
        if (kind == KIND_POLL_EXT && fr[int'(LEN_POLL) - 1] == trl_val)
            fr[int'(LEN_POLL) - 1] = ~trl_val;
        csum = 8'h00;
        for (int i = 2; i < len - 2; i++)
            csum += fr[i];
        fr[len - 2] = csum;
        fr[len - 1] = trl_val;

        keep = len;
        if (how == FRAME_DAMAGED) begin
            pos = $urandom_range(len - 1, 1);
            fr[pos] ^= byte_t'($urandom_range(255, 1));
        end else if (how == FRAME_CUT) begin
            keep = $urandom_range(len - 1, 1);
        end
        for (int i = 0; i < keep; i++)
            stim_bytes = {stim_bytes, fr[i]};
    endtask

    // Mostly good frames with random content, the rest damaged, cut or plain noise
    task automatic fill_random(input int target);
        int    pick;
        int    n;
        kind_t kind;
        while (stim_bytes.size() < target) begin
            pick = $urandom_range(99);
            kind = kind_t'($urandom_range(2));
            if (pick < 40) begin
                append_frame(KIND_SHORT, FRAME_INTACT);
            end else if (pick < 55) begin
                append_frame(KIND_POLL, FRAME_INTACT);
            end else if (pick < 67) begin
                append_frame(KIND_POLL_EXT, FRAME_INTACT);
            end else if (pick < 80) begin
                append_frame(kind, FRAME_DAMAGED);
            end else if (pick < 90) begin
                append_frame(kind, FRAME_CUT);
            end else begin
                n = $urandom_range(3, 1);
                repeat (n)
                    stim_bytes = {stim_bytes,
                                  ($urandom_range(3) == 0) ? hdr_val : byte_t'($urandom)};
            end
        end
    endtask

    // Send the queued bytes, pausing halfway until the block has drained
    task automatic send_stim();
        int half;
        half = stim_bytes.size() / 2;
        foreach (stim_bytes[i]) begin
            if (i == half)
                wait_drained();
            send_byte(stim_bytes[i]);
        end
        s_valid <= 1'b0;
        stim_bytes.delete();
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset codes: leading noise, good frame with byte extremes, wrong device code,
        // then another good frame
        stim_bytes = '{8'h00, 8'hFF,
                       HEADER_RST, DEVICE_RST, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFE, TRAILER_RST,
                       HEADER_RST, 8'h02, 8'h01, 8'h02, 8'h03, 8'h04, 8'h0A, TRAILER_RST,
                       HEADER_RST, DEVICE_RST, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFF, TRAILER_RST};
        send_stim();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            case (ph)
                0: begin
                    load_registers(8'h00, 8'h00, 8'h00, 8'h00);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    load_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                    tx_idle_pct  = 82;
                    rx_stall_pct = 0;
                end
                2: begin
                    load_registers(byte_t'($urandom), byte_t'($urandom),
                                   byte_t'($urandom), byte_t'($urandom));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 82;
                end
                3: begin
                    load_registers(HEADER_RST, TRAILER_RST, DEVICE_RST, POLL_RST);
                    tx_idle_pct  = 30;
                    rx_stall_pct = 30;
                end
                default: begin
                    load_registers(byte_t'($urandom), byte_t'($urandom),
                                   byte_t'($urandom), byte_t'($urandom));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            fill_random(PHASE_BYTES);
            send_stim();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Abort a run that hangs
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
